// File: sv/stbs_pkg.sv
// shared types and constants for the sorted table bound search
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANGE_W = 11;
  localparam int unsigned POS_W   = 11;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOWER    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPPER    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] value;
    logic [RANGE_W-1:0]        range_start;
    logic [RANGE_W-1:0]        range_end;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic check;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic search_done;
    logic need_check;
  } stat_t;

endpackage

// File: sv/stbs_ram.sv
// generic single write port, single read port ram with registered read
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/stbs_ctrl.sv
// controller: accept, probe loop, contains check, result strobe
module stbs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [stbs_pkg::MODE_W-1:0] mode,
  input  stbs_pkg::stat_t             stat,
  output stbs_pkg::cmd_t              cmd,
  output logic                        busy,
  output logic                        done
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (mode != MODE_LOAD) begin
            // empty or reversed range answers at once
            if (stat.empty) begin
              cmd.finish = 1'b1;
            end else begin
              state_next = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
        if (stat.search_done) begin
          if (stat.need_check) begin
            state_next = ST_CHECK;
          end else begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: sv/stbs_datapath.sv
// datapath: range clamp, lo/hi/mid registers, probe compare, table ram, result register
module stbs_datapath #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  stbs_pkg::req_t    req,
  input  stbs_pkg::cmd_t    cmd,
  output stbs_pkg::stat_t   stat,
  output stbs_pkg::result_t result
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WW = (PW > RANGE_W) ? PW : RANGE_W;
  localparam logic [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);

  logic signed [VALUE_W-1:0] key;
  logic [PW-1:0]             lo;
  logic [PW-1:0]             hi;
  logic [PW-1:0]             mid;
  logic [PW-1:0]             end_pos;
  logic                      strict;
  logic                      contains;

  logic [WW-1:0]             start_w;
  logic [WW-1:0]             end_w;
  logic [PW-1:0]             start_c;
  logic [PW-1:0]             end_c;
  logic signed [VALUE_W-1:0] rdata;
  logic                      pass;
  logic [PW-1:0]             lo_step;
  logic [PW-1:0]             hi_step;
  logic [PW-1:0]             lo_sel;
  logic [PW-1:0]             hi_sel;
  logic [PW-1:0]             span;
  logic [PW-1:0]             addr_n;
  logic                      we;
  logic                      re;

  // saturate range bounds to the table depth
  always_comb begin
    start_w = WW'(req.range_start);
    end_w   = WW'(req.range_end);
    start_c = (start_w > DEPTH_W) ? DEPTH_P : PW'(start_w);
    end_c   = (end_w > DEPTH_W) ? DEPTH_P : PW'(end_w);
  end

  assign we = cmd.accept && (req.mode == MODE_LOAD) && (WW'(req.entry_index) < DEPTH_W);
  assign re = cmd.accept | cmd.step;

  always_comb begin
    pass    = strict ? (rdata < key) : (rdata <= key);
    lo_step = pass ? (mid + PW'(1)) : lo;
    hi_step = pass ? hi : mid;
    lo_sel  = cmd.accept ? start_c : lo_step;
    hi_sel  = cmd.accept ? end_c : hi_step;
    span    = hi_sel - lo_sel;
    // next probe address, or the final position for the contains check
    addr_n  = (lo_sel < hi_sel) ? (lo_sel + (span >> 1)) : lo_sel;
  end

  always_comb begin
    stat.empty       = (start_c >= end_c);
    stat.search_done = (lo_step >= hi_step);
    stat.need_check  = contains && (lo_step < end_pos);
  end

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(req.entry_index)),
    .wdata (req.value),
    .re    (re),
    .raddr (AW'(addr_n)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key      <= req.value;
      lo       <= start_c;
      hi       <= end_c;
      end_pos  <= end_c;
      strict   <= (req.mode != MODE_UPPER);
      contains <= (req.mode == MODE_CONTAINS);
      mid      <= addr_n;
    end else if (cmd.step) begin
      lo  <= lo_step;
      hi  <= hi_step;
      mid <= addr_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.check) begin
        result.position <= POS_W'(lo);
        result.found    <= (rdata == key);
      end else if (cmd.step) begin
        result.position <= POS_W'(lo_step);
        result.found    <= 1'b0;
      end else begin
        result.position <= POS_W'(start_c);
        result.found    <= 1'b0;
      end
    end
  end

endmodule

// File: sv/sorted_table_bound_search.sv
// top level of the sorted table bound search: controller, datapath and checks
//
//  channel   ports                 beat taken when
//  --------  --------------------  ----------------------------
//  request   start, busy, req      start high while busy low
//  result    done, result          done high (one cycle, no stall)
//
// a load writes its table entry at accept, leaves the block idle and gives no result.
// a query is accepted, then makes one probe per step of the probe loop (one table
// ram read each, at most ceil(log2(n+1)) probes for a range of n entries, 11 at depth
// 1024), plus a check step for the equality read in contains mode; done follows
// in the next cycle. an empty or reversed range strobes done the cycle after
// accept. rst clears the controller only; table entries are undefined until
// loaded. the receiver cannot stall results.
module sorted_table_bound_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  stbs_pkg::req_t    req,
  output logic              done,
  output stbs_pkg::result_t result
);
  import stbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  stbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (req.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

  // a result beat never overlaps a search in progress
  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(busy && done))
    else $error("result strobe while a search is running");

  // found can only come out of the equality check cycle
  a_found_from_check: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> $past(cmd.check))
    else $error("found set without a contains check");

  // a non-empty query always enters the probe loop
  a_query_starts_search: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.mode != MODE_LOAD) && !stat.empty) |=> busy)
    else $error("query accepted but no search started");

endmodule

// File: sim/bound_search_checker.sv
// checker for the sorted table bound search: mirrors loads, predicts every query result
module bound_search_checker #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  stbs_pkg::req_t    req,
  input  logic              done,
  input  stbs_pkg::result_t result,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  import stbs_pkg::*;

  logic signed [VALUE_W-1:0] day_table [TABLE_DEPTH];
  result_t                   expected_bounds [$];
  int unsigned               mismatches;

  // binary search over the mirrored table, same midpoint rule as the block
  function automatic result_t predict_bound(req_t q);
    int unsigned               lo;
    int unsigned               hi;
    int unsigned               mid;
    logic signed [VALUE_W-1:0] probe;
    logic                      passed;
    result_t                   res;
    lo = (q.range_start > TABLE_DEPTH) ? TABLE_DEPTH : q.range_start;
    hi = (q.range_end > TABLE_DEPTH) ? TABLE_DEPTH : q.range_end;
    res.found = 1'b0;
    while (lo < hi) begin
      mid    = lo + (hi - lo) / 2;
      probe  = day_table[mid];
      passed = (q.mode == MODE_UPPER) ? (probe <= $signed(q.value))
                                      : (probe < $signed(q.value));
      if (passed) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    // hi has collapsed onto lo, so compare against the saturated end again
    if (q.mode == MODE_CONTAINS && lo < ((q.range_end > TABLE_DEPTH) ? TABLE_DEPTH : q.range_end))
      res.found = (day_table[lo] == $signed(q.value));
    res.position = lo[POS_W-1:0];
    return res;
  endfunction

  function automatic void log_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_bounds.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (expected_bounds.size() == 0) begin
          log_failure($sformatf("result beat with nothing expected: pos %0d found %0b",
                                result.position, result.found));
        end else begin
          want = expected_bounds.pop_front();
          if (result.position !== want.position || result.found !== want.found)
            log_failure($sformatf(
              "bound mismatch: expected pos %0d found %0b, got pos %0d found %0b",
              want.position, want.found, result.position, result.found));
        end
      end
      if (start && !busy) begin
        if (req.mode == MODE_LOAD) begin
          if (req.entry_index < TABLE_DEPTH) day_table[req.entry_index] = req.value;
        end else begin
          expected_bounds.push_back(predict_bound(req));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_bounds.size();
  end

endmodule

// File: sim/sorted_table_bound_search_tb.sv
// testbench top for the sorted table bound search: stimulus, watchdog and verdict
module sorted_table_bound_search_tb;
  import stbs_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEFAULT;
  localparam int unsigned IDLE_LIMIT   = 500;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam int unsigned END_CYCLES   = 20;
  localparam longint      DAY_MIN      = -64'sd2147483648;
  localparam longint      DAY_MAX      = 64'sd2147483647;

  typedef enum {FILL_DUPS, FILL_SPREAD, FILL_PLATEAUS} fill_kind_e;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  req_t        req   = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left = 0;

  // stimulus-side copy of the table, used to pick meaningful keys and sorted load days
  logic signed [VALUE_W-1:0] shadow_days [DEPTH];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_table_bound_search #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  bound_search_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic longint rand_span(longint span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % (longint'(span) + 1));
  endfunction

  function automatic req_t make_query(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] key,
                                      int unsigned rs, int unsigned re);
    req_t q;
    q.mode        = mode;
    q.entry_index = INDEX_W'($urandom);
    q.value       = key;
    q.range_start = rs[RANGE_W-1:0];
    q.range_end   = re[RANGE_W-1:0];
    return q;
  endfunction

  function automatic req_t make_load(int unsigned idx, logic [VALUE_W-1:0] day);
    req_t q;
    q.mode        = MODE_LOAD;
    q.entry_index = idx[INDEX_W-1:0];
    q.value       = day;
    q.range_start = RANGE_W'($urandom);
    q.range_end   = RANGE_W'($urandom);
    return q;
  endfunction

  function automatic req_t random_query();
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] key;
    int unsigned        rs;
    int unsigned        re;
    int unsigned        s;
    int unsigned        e;
    int unsigned        pick;
    mode = MODE_W'($urandom_range(MODE_CONTAINS, MODE_LOWER));
    pick = $urandom_range(99);
    if (pick < 50) begin
      rs = $urandom_range(DEPTH);
      re = rs + $urandom_range(DEPTH - rs);
    end else if (pick < 65) begin
      rs = $urandom_range(DEPTH - 1);
      re = rs + $urandom_range(4, 1);
      if (re > DEPTH) re = DEPTH;
    end else if (pick < 75) begin
      rs = 0;
      re = DEPTH;
    end else if (pick < 85) begin
      re = $urandom_range(DEPTH);
      rs = $urandom_range(2047, re);
    end else begin
      rs = $urandom_range(2047);
      re = $urandom_range(2047);
    end
    s = (rs > DEPTH) ? DEPTH : rs;
    e = (re > DEPTH) ? DEPTH : re;
    pick = $urandom_range(99);
    if (pick < 45 && s < e) begin
      key = shadow_days[$urandom_range(e - 1, s)];
    end else if (pick < 60 && s < e) begin
      key = shadow_days[$urandom_range(e - 1, s)];
      key = $urandom_range(1) ? key + 1 : key - 1;
    end else if (pick < 70) begin
      key = $urandom_range(1) ? DAY_MAX[VALUE_W-1:0] : DAY_MIN[VALUE_W-1:0];
    end else begin
      key = $urandom;
    end
    return make_query(mode, key, rs, re);
  endfunction

  // one request beat; bursts of random length with random gaps in between
  task automatic send_beat(input req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(15, 1);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start      <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic fill_table(input fill_kind_e kind);
    longint acc;
    longint step;
    step = (DAY_MAX - DAY_MIN) / (DEPTH - 1);
    case (kind)
      FILL_DUPS: begin
        acc = longint'($signed($urandom));
        if (acc > DAY_MAX - longint'(4 * DEPTH)) acc -= longint'(4 * DEPTH);
      end
      FILL_PLATEAUS: acc = DAY_MIN + $urandom_range(1000);
      default:       acc = DAY_MIN;
    endcase
    for (int unsigned i = 0; i < DEPTH; i++) begin
      case (kind)
        FILL_DUPS: acc += $urandom_range(3);
        FILL_PLATEAUS: begin
          // long runs of equal days with rare jumps
          if ($urandom_range(63) == 0) acc += $urandom_range(4000000, 1);
          if (acc > DAY_MAX) acc = DAY_MAX;
        end
        default: acc = (i == DEPTH - 1) ? DAY_MAX : DAY_MIN + longint'(i) * step;
      endcase
      shadow_days[i] = acc[VALUE_W-1:0];
      send_beat(make_load(i, acc[VALUE_W-1:0]));
    end
  endtask

  task automatic random_load();
    int unsigned        idx;
    longint             lo;
    longint             hi;
    logic [VALUE_W-1:0] day;
    idx = $urandom_range(DEPTH - 1);
    if ($urandom_range(9) < 7) begin
      // keep the table sorted: pick a day between the neighbors
      lo  = (idx > 0) ? longint'(shadow_days[idx - 1]) : DAY_MIN;
      hi  = (idx < DEPTH - 1) ? longint'(shadow_days[idx + 1]) : DAY_MAX;
      day = (hi < lo) ? lo[VALUE_W-1:0] : VALUE_W'(lo + rand_span(hi - lo));
    end else begin
      day = $urandom;
    end
    shadow_days[idx] = day;
    send_beat(make_load(idx, day));
  endtask

  // watchdog on cycles in which no beat moves on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0] query_modes [3];
    query_modes = '{MODE_LOWER, MODE_UPPER, MODE_CONTAINS};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty ranges use no table data, so they are safe before the table is filled
    send_beat(make_query(MODE_LOWER, DAY_MIN[VALUE_W-1:0], 0, 0));
    send_beat(make_query(MODE_UPPER, DAY_MAX[VALUE_W-1:0], DEPTH, 0));
    send_beat(make_query(MODE_CONTAINS, '0, 2047, 2047));

    // one full fill, table shape picked at random
    fill_table(fill_kind_e'($urandom_range(2)));

    foreach (query_modes[m]) begin
      send_beat(make_query(query_modes[m], DAY_MIN[VALUE_W-1:0], 0, DEPTH));
      send_beat(make_query(query_modes[m], DAY_MAX[VALUE_W-1:0], 0, DEPTH));
      send_beat(make_query(query_modes[m], shadow_days[512], 0, DEPTH));
      send_beat(make_query(query_modes[m], shadow_days[300], 300, 301));
    end
    // saturated and reversed ranges
    send_beat(make_query(MODE_LOWER, shadow_days[700], 5, 2000));
    send_beat(make_query(MODE_UPPER, shadow_days[10], 2047, 2047));
    send_beat(make_query(MODE_CONTAINS, shadow_days[3], 1500, 3));
    send_beat(make_query(MODE_LOWER, shadow_days[400], 600, 200));
    // extreme days at both ends of the table
    shadow_days[DEPTH - 1] = DAY_MAX[VALUE_W-1:0];
    send_beat(make_load(DEPTH - 1, DAY_MAX[VALUE_W-1:0]));
    send_beat(make_query(MODE_CONTAINS, DAY_MAX[VALUE_W-1:0], 0, DEPTH));
    shadow_days[0] = DAY_MIN[VALUE_W-1:0];
    send_beat(make_load(0, DAY_MIN[VALUE_W-1:0]));
    send_beat(make_query(MODE_CONTAINS, DAY_MIN[VALUE_W-1:0], 0, DEPTH));

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(9) == 0) random_load();
      else send_beat(random_query());
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
